// ===== hdl/aunp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aunp_pkg
// Shared types, character codes and helpers for the ASCII unsigned number
// parser.
// ----------------------------------------------------------------------------
package aunp_pkg;

    // Field and port widths
    localparam int CH_BITS           = 8;
    localparam int RADIX_BITS        = 6;
    localparam int OFFSET_BITS       = 16;
    localparam int APB_ADDR_BITS     = 3;
    localparam int APB_DATA_BITS     = 32;
    localparam int VALUE_BITS_DEF    = 64;
    localparam int POSITION_BITS_DEF = 16;

    // Register map: word index taken from paddr[2]
    localparam logic REG_NUMBER_BASE = 1'b0;

    // Radix values
    localparam logic [RADIX_BITS-1:0] RADIX_AUTO  = 6'd0;
    localparam logic [RADIX_BITS-1:0] RADIX_BAD   = 6'd1;
    localparam logic [RADIX_BITS-1:0] RADIX_OCT   = 6'd8;
    localparam logic [RADIX_BITS-1:0] RADIX_DEC   = 6'd10;
    localparam logic [RADIX_BITS-1:0] RADIX_HEX   = 6'd16;
    localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_BITS-1:0] BASE_RESET  = RADIX_DEC;
    localparam logic [RADIX_BITS-1:0] NOT_DIGIT   = 6'd63;
    localparam logic [RADIX_BITS-1:0] DIGIT_TEN   = 6'd10;

    // Character codes
    localparam logic [CH_BITS-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_BITS-1:0] CH_CR    = 8'h0d;
    localparam logic [CH_BITS-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_BITS-1:0] CH_PLUS  = 8'h2b;
    localparam logic [CH_BITS-1:0] CH_MINUS = 8'h2d;
    localparam logic [CH_BITS-1:0] CH_0     = 8'h30;
    localparam logic [CH_BITS-1:0] CH_9     = 8'h39;
    localparam logic [CH_BITS-1:0] CH_A_UP  = 8'h41;
    localparam logic [CH_BITS-1:0] CH_X_UP  = 8'h58;
    localparam logic [CH_BITS-1:0] CH_Z_UP  = 8'h5a;
    localparam logic [CH_BITS-1:0] CH_A_LO  = 8'h61;
    localparam logic [CH_BITS-1:0] CH_X_LO  = 8'h78;
    localparam logic [CH_BITS-1:0] CH_Z_LO  = 8'h7a;

    // Parse phases
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD,
        PH_FIRST,
        PH_ZERO,
        PH_XSEEN,
        PH_DIGITS
    } t_phase;

    // Digit value of a character, NOT_DIGIT when it is none
    function automatic logic [RADIX_BITS-1:0] digit_of(input logic [CH_BITS-1:0] c);
        logic [RADIX_BITS-1:0] d;
        d = NOT_DIGIT;
        if (c >= CH_0 && c <= CH_9) begin
            d = RADIX_BITS'(c - CH_0);
        end else if (c >= CH_A_LO && c <= CH_Z_LO) begin
            d = RADIX_BITS'(c - CH_A_LO) + DIGIT_TEN;
        end else if (c >= CH_A_UP && c <= CH_Z_UP) begin
            d = RADIX_BITS'(c - CH_A_UP) + DIGIT_TEN;
        end
        return d;
    endfunction

    // Space, tab, LF, VT, FF, CR
    function automatic logic is_space(input logic [CH_BITS-1:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage

// ===== hdl/aunp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aunp_if
// Valid/ready channels of the number parser: characters in, results out.
// ----------------------------------------------------------------------------
interface aunp_char_if;
    logic                         valid;
    logic                         ready;
    logic [aunp_pkg::CH_BITS-1:0] ch;
    logic                         start_req;

    modport source (output valid, ch, start_req, input ready);
    modport sink   (input valid, ch, start_req, output ready);
endinterface

interface aunp_result_if #(
    parameter int VALUE_BITS = aunp_pkg::VALUE_BITS_DEF
);
    logic                             valid;
    logic                             ready;
    logic [VALUE_BITS-1:0]            value;
    logic [aunp_pkg::OFFSET_BITS-1:0] end_offset;
    logic                             overflowed;
    logic                             digits_found;

    modport source (output valid, value, end_offset, overflowed, digits_found,
                    input ready);
    modport sink   (input valid, value, end_offset, overflowed, digits_found,
                    output ready);
endinterface

// ===== hdl/ascii_unsigned_number_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_unsigned_number_parser
// Stream strtoul: one character per item, one result item per parsed number.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  i_in      in   valid/ready        ch[7:0], start_req
//  o_out     out  valid/ready        value, end_offset[15:0], overflowed,
//                                    digits_found
//  apb       in   psel/penable       paddr[2:0], pwdata[31:0] -> number_base
//
//  One character per clock while no held result stalls the input. A character
//  waits in the input register; the parse step then updates the parse state
//  and, when the character ends a number, loads the result register.
//  The single 64x6 multiply-add of the digit step sets the cycle time.
//  Reset is synchronous: parser idle, number_base 10, both registers empty.
//  A held result stalls the input register; i_in.ready drops only when both
//  registers are full and the result is not taken.
// ----------------------------------------------------------------------------
module ascii_unsigned_number_parser #(
    parameter int VALUE_BITS    = aunp_pkg::VALUE_BITS_DEF,
    parameter int POSITION_BITS = aunp_pkg::POSITION_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    aunp_char_if.sink                             i_in,
    aunp_result_if.source                         o_out,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [aunp_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [aunp_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [aunp_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                  pready
);

    localparam int RB = aunp_pkg::RADIX_BITS;
    localparam int WB = VALUE_BITS + RB;

    // Configuration register
    logic [RB-1:0] r_base;

    // Input register
    logic                         r_in_valid;
    logic [aunp_pkg::CH_BITS-1:0] r_ch;
    logic                         r_start;

    // Parse state
    aunp_pkg::t_phase         r_phase, n_phase;
    logic                     r_minus, n_minus;
    logic [RB-1:0]            r_radix, n_radix;
    logic [VALUE_BITS-1:0]    r_acc, n_acc;
    logic                     r_ovf, n_ovf;
    logic                     r_dig, n_dig;
    logic [POSITION_BITS-1:0] r_pos, n_pos;

    // Result register
    logic                             r_out_valid;
    logic [VALUE_BITS-1:0]            r_value, n_value;
    logic [aunp_pkg::OFFSET_BITS-1:0] r_offset, n_offset;
    logic                             r_out_ovf, n_out_ovf;
    logic                             r_out_dig, n_out_dig;

    // Step control
    aunp_pkg::t_phase         e_phase;
    logic                     e_minus, e_ovf, e_dig;
    logic [RB-1:0]            e_radix;
    logic [VALUE_BITS-1:0]    e_acc;
    logic [POSITION_BITS-1:0] e_pos, w_pos_base;
    logic [RB-1:0]            w_digit, w_rad, w_rad1;
    logic [WB-1:0]            w_prod;
    logic                     w_first, w_offer, w_emit, w_bad, w_inc, w_pre_inc;
    logic                     w_adv, w_step, w_cfg_wr;

    // ---- configuration port ----
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite
                      && (paddr[2] == aunp_pkg::REG_NUMBER_BASE);
    assign prdata   = (paddr[2] == aunp_pkg::REG_NUMBER_BASE)
                      ? aunp_pkg::APB_DATA_BITS'(r_base) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= aunp_pkg::BASE_RESET;
        end else if (w_cfg_wr) begin
            r_base <= pwdata[RB-1:0];
        end
    end

    // ---- handshake ----
    assign w_adv      = !r_out_valid || o_out.ready;
    assign w_step     = r_in_valid && w_adv;
    assign i_in.ready = !r_in_valid || w_adv;

    // Capture an item into the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_ch    <= i_in.ch;
            r_start <= i_in.start_req;
        end
    end

    // ---- one parse step ----
    always_comb begin
        // A start restarts the parse on this character
        if (r_start) begin
            e_phase = aunp_pkg::PH_LEAD;
            e_minus = 1'b0;
            e_radix = r_base;
            e_acc   = '0;
            e_ovf   = 1'b0;
            e_dig   = 1'b0;
            e_pos   = '0;
        end else begin
            e_phase = r_phase;
            e_minus = r_minus;
            e_radix = r_radix;
            e_acc   = r_acc;
            e_ovf   = r_ovf;
            e_dig   = r_dig;
            e_pos   = r_pos;
        end

        n_phase   = e_phase;
        n_minus   = e_minus;
        n_radix   = e_radix;
        n_acc     = e_acc;
        n_ovf     = e_ovf;
        n_dig     = e_dig;
        w_digit   = aunp_pkg::digit_of(r_ch);
        w_rad     = e_radix;
        w_rad1    = e_radix;
        w_first   = 1'b0;
        w_offer   = 1'b0;
        w_emit    = 1'b0;
        w_bad     = 1'b0;
        w_inc     = 1'b0;
        w_pre_inc = 1'b0;

        unique case (e_phase)
            aunp_pkg::PH_IDLE: begin
            end
            aunp_pkg::PH_LEAD: begin
                if (aunp_pkg::is_space(r_ch)) begin
                    w_inc = 1'b1;
                end else if (r_ch == aunp_pkg::CH_PLUS || r_ch == aunp_pkg::CH_MINUS) begin
                    n_minus = (r_ch == aunp_pkg::CH_MINUS);
                    n_phase = aunp_pkg::PH_FIRST;
                    w_inc   = 1'b1;
                end else begin
                    w_first = 1'b1;
                end
            end
            aunp_pkg::PH_FIRST: begin
                w_first = 1'b1;
            end
            aunp_pkg::PH_ZERO: begin
                if (r_ch == aunp_pkg::CH_X_LO || r_ch == aunp_pkg::CH_X_UP) begin
                    // 'x' is counted only once a hex digit follows
                    n_radix = aunp_pkg::RADIX_HEX;
                    n_phase = aunp_pkg::PH_XSEEN;
                end else begin
                    w_rad   = (e_radix == aunp_pkg::RADIX_AUTO) ? aunp_pkg::RADIX_OCT
                                                                : e_radix;
                    n_radix = w_rad;
                    w_offer = 1'b1;
                end
            end
            aunp_pkg::PH_XSEEN: begin
                if (w_digit < aunp_pkg::RADIX_HEX) begin
                    w_pre_inc = 1'b1;
                    w_offer   = 1'b1;
                end else begin
                    w_emit = 1'b1;
                end
            end
            aunp_pkg::PH_DIGITS: begin
                w_offer = 1'b1;
            end
            default: begin
            end
        endcase

        // First character after whitespace and sign: pick the radix
        if (w_first) begin
            w_rad1 = (e_radix == aunp_pkg::RADIX_AUTO && r_ch != aunp_pkg::CH_0)
                     ? aunp_pkg::RADIX_DEC : e_radix;
            n_radix = w_rad1;
            if (w_rad1 == aunp_pkg::RADIX_BAD || w_rad1 > aunp_pkg::RADIX_MAX) begin
                w_emit = 1'b1;
                w_bad  = 1'b1;
            end else if (r_ch == aunp_pkg::CH_0 && (w_rad1 == aunp_pkg::RADIX_AUTO
                                                    || w_rad1 == aunp_pkg::RADIX_HEX)) begin
                n_dig   = 1'b1;
                n_phase = aunp_pkg::PH_ZERO;
                w_inc   = 1'b1;
            end else begin
                w_rad   = w_rad1;
                w_offer = 1'b1;
            end
        end

        // Digit step: acc * radix + digit, carry-out bits flag overflow
        w_prod = WB'(e_acc) * WB'(w_rad) + WB'(w_digit);
        if (w_offer) begin
            if (w_digit >= w_rad) begin
                w_emit = 1'b1;
            end else begin
                n_acc   = w_prod[VALUE_BITS-1:0];
                n_ovf   = e_ovf || (|w_prod[WB-1:VALUE_BITS]);
                n_dig   = 1'b1;
                n_phase = aunp_pkg::PH_DIGITS;
                w_inc   = 1'b1;
            end
        end

        if (w_emit) begin
            n_phase = aunp_pkg::PH_IDLE;
            w_inc   = 1'b0;
        end

        // Saturating position count
        w_pos_base = (w_pre_inc && !(&e_pos)) ? e_pos + POSITION_BITS'(1) : e_pos;
        n_pos      = (w_inc && !(&w_pos_base)) ? w_pos_base + POSITION_BITS'(1)
                                               : w_pos_base;

        // Result fields, taken from the state before this character
        n_out_dig = e_dig && !w_bad;
        if (!n_out_dig) begin
            n_value = '0;
        end else if (e_ovf) begin
            n_value = '1;
        end else if (e_minus) begin
            n_value = '0 - e_acc;
        end else begin
            n_value = e_acc;
        end
        n_offset  = n_out_dig ? aunp_pkg::OFFSET_BITS'(e_pos) : '0;
        n_out_ovf = n_out_dig && e_ovf;
    end

    // Advance parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= aunp_pkg::PH_IDLE;
            r_minus <= 1'b0;
            r_radix <= '0;
            r_acc   <= '0;
            r_ovf   <= 1'b0;
            r_dig   <= 1'b0;
            r_pos   <= '0;
        end else if (w_step) begin
            r_phase <= n_phase;
            r_minus <= n_minus;
            r_radix <= n_radix;
            r_acc   <= n_acc;
            r_ovf   <= n_ovf;
            r_dig   <= n_dig;
            r_pos   <= n_pos;
        end
    end

    // ---- result register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_step && w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_emit) begin
            r_value   <= n_value;
            r_offset  <= n_offset;
            r_out_ovf <= n_out_ovf;
            r_out_dig <= n_out_dig;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.value        = r_value;
    assign o_out.end_offset   = r_offset;
    assign o_out.overflowed   = r_out_ovf;
    assign o_out.digits_found = r_out_dig;

`ifndef SYNTHESIS
    // A number without digits reports all zeros
    a_no_digit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_dig |-> r_value == '0 && r_offset == '0 && !r_out_ovf)
        else $error("result without digits carries nonzero fields");

    // Overflow forces an all-ones value
    a_ovf_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_ovf |-> (&r_value))
        else $error("overflowed result is not all ones");

    // A fresh result leaves the parser idle
    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> r_phase == aunp_pkg::PH_IDLE)
        else $error("parser not idle after emitting a result");

    // A stalled input register keeps its item
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid && $stable(r_ch) && $stable(r_start))
        else $error("input register changed while stalled");
`endif

endmodule
